@@ sv/ubx_time_frame_receiver_unit_assert.svh @@
// assertion macros for the ubx time frame receiver
`ifndef UBX_TIME_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define UBX_TIME_FRAME_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define UBXTF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ubxtf assertion failed");
`define UBXTF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ubxtf assertion failed");
`else
`define UBXTF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UBXTF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/ubxtf_pkg.sv @@
// shared constants and types of the ubx time frame receiver
package ubxtf_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 32;
  localparam int unsigned CAPTURE_LEN     = 20;
  localparam int unsigned CAP_W           = $clog2(CAPTURE_LEN);
  localparam int unsigned HDR_BYTES       = 6;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] CLASS_NAV   = 8'h01;
  localparam logic [7:0] ID_TIMEUTC  = 8'h21;
  localparam logic [7:0] ID_CLOCK    = 8'h22;

  localparam logic [31:0] PPS_WINDOW_RST = 32'd1000000;
  localparam logic [31:0] ACCURACY_RST   = 32'hFFFF_FFFF;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_PPS  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] KIND_TIME = 2'd0;
  localparam logic [1:0] KIND_ACC  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // reciprocal constants: floor(2^sh / divisor)
  localparam logic signed [32:0] K_DIV1000 = 33'sd2199023255;
  localparam int unsigned        SH_DIV1000 = 41;
  localparam logic signed [32:0] K_DIV400  = 33'sd671088;
  localparam int unsigned        SH_DIV400  = 28;
  localparam logic signed [32:0] K_DIV5    = 33'sd209715;
  localparam int unsigned        SH_DIV5    = 20;

  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [31:0] nano;
  } date_fields_t;

endpackage

@@ sv/ubxtf_date_unit.sv @@
// date to unix microseconds sequencer around one shared multiplier
module ubxtf_date_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ubxtf_pkg::date_fields_t fields_i,
  output logic                  done_o,
  output logic [63:0]           utc_us_o,
  output logic signed [31:0]    nano_us_o
);
  import ubxtf_pkg::*;

  localparam logic [4:0] D_IDLE = 5'd0;
  localparam logic [4:0] D_N1   = 5'd1;
  localparam logic [4:0] D_N2   = 5'd2;
  localparam logic [4:0] D_N3   = 5'd3;
  localparam logic [4:0] D_Q    = 5'd4;
  localparam logic [4:0] D_R    = 5'd5;
  localparam logic [4:0] D_DOY1 = 5'd6;
  localparam logic [4:0] D_DOY2 = 5'd7;
  localparam logic [4:0] D_DOY3 = 5'd8;
  localparam logic [4:0] D_DOE  = 5'd9;
  localparam logic [4:0] D_DAYS = 5'd10;
  localparam logic [4:0] D_H    = 5'd11;
  localparam logic [4:0] D_M    = 5'd12;
  localparam logic [4:0] D_SECS = 5'd13;
  localparam logic [4:0] D_UL   = 5'd14;
  localparam logic [4:0] D_UH   = 5'd15;

  logic [4:0]         st_q, st_d;
  logic               done_q, done_d;
  date_fields_t       f_q, f_d;
  logic [31:0]        nabs_q, nabs_d;
  logic               nneg_q, nneg_d;
  logic [31:0]        nq_q, nq_d;
  logic [8:0]         era_q, era_d;
  logic [8:0]         yoe_q, yoe_d;
  logic [15:0]        t_q, t_d;
  logic [13:0]        q5_q, q5_d;
  logic [15:0]        doy_q, doy_d;
  logic [19:0]        doe_q, doe_d;
  logic signed [63:0] acc_q, acc_d;
  logic [63:0]        utc_q, utc_d;
  logic [63:0]        prod_q;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod_full;

  logic [16:0] yr;
  logic [7:0]  mp;
  logic [1:0]  c100;
  logic [31:0] r32, qn;
  logic [16:0] r17;
  logic [15:0] r16;
  logic [13:0] q5c;
  logic signed [33:0] days;
  logic signed [63:0] secs;

  assign prod_full = mul_a * mul_b;

  assign yr = 17'(f_q.year) + 17'd400 - ((f_q.month <= 8'd2) ? 17'd1 : 17'd0);
  assign mp = (f_q.month > 8'd2) ? f_q.month - 8'd3 : f_q.month + 8'd9;
  assign c100 = (yoe_q >= 9'd300) ? 2'd3 : (yoe_q >= 9'd200) ? 2'd2 :
                (yoe_q >= 9'd100) ? 2'd1 : 2'd0;

  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    f_d    = f_q;
    nabs_d = nabs_q;
    nneg_d = nneg_q;
    nq_d   = nq_q;
    era_d  = era_q;
    yoe_d  = yoe_q;
    t_d    = t_q;
    q5_d   = q5_q;
    doy_d  = doy_q;
    doe_d  = doe_q;
    acc_d  = acc_q;
    utc_d  = utc_q;
    mul_a  = '0;
    mul_b  = '0;
    r32    = nabs_q - prod_q[31:0];
    qn     = nq_q + ((r32 >= 32'd1000) ? 32'd1 : 32'd0);
    r17    = yr - prod_q[16:0];
    r16    = t_q - prod_q[15:0];
    q5c    = q5_q + ((r16 >= 16'd5) ? 14'd1 : 14'd0);
    days   = $signed(prod_q[33:0]) + 34'($signed(doe_q)) - 34'sd719468;
    secs   = acc_q + $signed(prod_q) + $signed({56'd0, f_q.second});
    unique case (st_q)
      D_IDLE: begin
        if (start_i) begin
          f_d    = fields_i;
          nneg_d = fields_i.nano[31];
          nabs_d = fields_i.nano[31] ? (32'd0 - fields_i.nano) : fields_i.nano;
          st_d   = D_N1;
        end
      end
      D_N1: begin
        mul_a = $signed({2'b00, nabs_q});
        mul_b = K_DIV1000;
        st_d  = D_N2;
      end
      D_N2: begin
        nq_d  = 32'(prod_q[SH_DIV1000 +: 23]);
        mul_a = $signed({2'b00, 32'(prod_q[SH_DIV1000 +: 23])});
        mul_b = 33'sd1000;
        st_d  = D_N3;
      end
      D_N3: begin
        nq_d  = nneg_q ? (32'd0 - qn) : qn;
        mul_a = $signed({17'd0, yr});
        mul_b = K_DIV400;
        st_d  = D_Q;
      end
      D_Q: begin
        era_d = prod_q[SH_DIV400 +: 9];
        mul_a = $signed({25'd0, prod_q[SH_DIV400 +: 9]});
        mul_b = 33'sd400;
        st_d  = D_R;
      end
      D_R: begin
        if (r17 >= 17'd400) begin
          era_d = era_q + 9'd1;
          yoe_d = 9'(r17 - 17'd400);
        end else begin
          yoe_d = r17[8:0];
        end
        mul_a = $signed({26'd0, mp});
        mul_b = 33'sd153;
        st_d  = D_DOY1;
      end
      D_DOY1: begin
        t_d   = prod_q[15:0] + 16'd2;
        mul_a = $signed({18'd0, prod_q[15:0] + 16'd2});
        mul_b = K_DIV5;
        st_d  = D_DOY2;
      end
      D_DOY2: begin
        q5_d  = prod_q[SH_DIV5 +: 14];
        mul_a = $signed({20'd0, prod_q[SH_DIV5 +: 14]});
        mul_b = 33'sd5;
        st_d  = D_DOY3;
      end
      D_DOY3: begin
        // day zero lands one before day one, so doy may go negative
        doy_d = {2'b00, q5c} + 16'(f_q.day) - 16'd1;
        mul_a = $signed({25'd0, yoe_q});
        mul_b = 33'sd365;
        st_d  = D_DOE;
      end
      D_DOE: begin
        doe_d = 20'(prod_q[17:0]) + 20'(yoe_q[8:2]) - 20'(c100) +
                20'($signed(doy_q));
        mul_a = $signed({25'd0, era_q}) - 34'sd1;
        mul_b = 33'sd146097;
        st_d  = D_DAYS;
      end
      D_DAYS: begin
        mul_a = days;
        mul_b = 33'sd86400;
        st_d  = D_H;
      end
      D_H: begin
        acc_d = $signed(prod_q);
        mul_a = $signed({26'd0, f_q.hour});
        mul_b = 33'sd3600;
        st_d  = D_M;
      end
      D_M: begin
        acc_d = acc_q + $signed(prod_q);
        mul_a = $signed({26'd0, f_q.minute});
        mul_b = 33'sd60;
        st_d  = D_SECS;
      end
      D_SECS: begin
        // seconds times 1e6 in two halves: low 21 bits, then the rest
        acc_d = secs;
        mul_a = $signed({13'd0, secs[20:0]});
        mul_b = 33'sd1000000;
        st_d  = D_UL;
      end
      D_UL: begin
        utc_d = prod_q;
        mul_a = $signed(acc_q[54:21]);
        mul_b = 33'sd1000000;
        st_d  = D_UH;
      end
      D_UH: begin
        utc_d  = utc_q + {prod_q[42:0], 21'd0};
        done_d = 1'b1;
        st_d   = D_IDLE;
      end
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    nabs_q <= nabs_d;
    nneg_q <= nneg_d;
    nq_q   <= nq_d;
    era_q  <= era_d;
    yoe_q  <= yoe_d;
    t_q    <= t_d;
    q5_q   <= q5_d;
    doy_q  <= doy_d;
    doe_q  <= doe_d;
    acc_q  <= acc_d;
    utc_q  <= utc_d;
    prod_q <= prod_full[63:0];
  end

  assign done_o    = done_q;
  assign utc_us_o  = utc_q;
  assign nano_us_o = $signed(nq_q);

endmodule

@@ sv/ubx_time_frame_receiver_unit.sv @@
// top level: ubx frame parser, pps alignment and clock offset registers
//
// channel  | direction | handshake             | word
// in       | sink      | in_valid_i/in_stall_o | mode, rx_byte, now_us
// out      | source    | out_valid_o/out_stall_i | kind, offset, correction, accuracy, utc now
// cfg      | sink      | cfg_valid_i/cfg_ready_o | pps window in microseconds
//
// a word is taken into a holding register, then executed once the output
// register is free; the input stalls meanwhile, so a new word is taken only after the last one is done.
// a completed nav-timeutc frame holds the input through 15 steps of the
// shared multiplier sequencer and its done strobe, which applies the offset,
// and then through the load of the output register.
// after reset the parser sits in overrun and drops the first byte.
// no clearing pass; the payload capture bytes are written before any read.
`include "ubx_time_frame_receiver_unit_assert.svh"
module ubx_time_frame_receiver_unit #(
  parameter int unsigned FRAME_BYTES = ubxtf_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [63:0]        now_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [63:0]        clock_offset_us_o,
  output logic signed [31:0] correction_us_o,
  output logic [31:0]        accuracy_ns_o,
  output logic [63:0]        utc_now_us_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import ubxtf_pkg::*;

  localparam int unsigned PW = $clog2(FRAME_BYTES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DATE = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [1:0]  mode_q;
  logic [7:0]  byte_q;
  logic [63:0] now_q;

  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  ck_a_q, ck_a_d;
  logic [7:0]  cap_q [CAPTURE_LEN];
  logic        cap_we;
  logic [CAP_W-1:0] cap_idx;

  logic [31:0] window_q;
  logic [63:0] pps_q, pps_d;
  logic [63:0] offset_q, offset_d;
  logic [63:0] old_q, old_d;
  logic [31:0] acc_q, acc_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [63:0] ooff_q, ooff_d;
  logic [31:0] corr_q, corr_d;
  logic [31:0] oacc_q, oacc_d;
  logic [63:0] outc_q, outc_d;

  logic        slot_free;
  logic        date_start, date_done;
  date_fields_t date_fields;
  logic [63:0] date_utc;
  logic signed [31:0] date_nano;

  logic [PW-1:0] k;
  logic [7:0]  sa_add, sb_add;
  logic        frame_ok;
  logic        recent;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign k = pos_q - PW'(HDR_BYTES);
  assign sa_add = ((pos_q == PW'(2)) ? 8'd0 : sum_a_q) + byte_q;
  assign sb_add = ((pos_q == PW'(2)) ? 8'd0 : sum_b_q) + sa_add;
  assign frame_ok = (ck_a_q == sum_a_q) && (byte_q == sum_b_q) &&
                    (class_q == CLASS_NAV) && (len_q == 16'(CAPTURE_LEN));
  assign recent = (now_q - pps_q) < {32'd0, window_q};
  assign cap_idx = k[CAP_W-1:0];

  assign date_fields = '{year:   {cap_q[13], cap_q[12]},
                         month:  cap_q[14],
                         day:    cap_q[15],
                         hour:   cap_q[16],
                         minute: cap_q[17],
                         second: cap_q[18],
                         nano:   {cap_q[11], cap_q[10], cap_q[9], cap_q[8]}};

  ubxtf_date_unit u_date (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (date_start),
    .fields_i  (date_fields),
    .done_o    (date_done),
    .utc_us_o  (date_utc),
    .nano_us_o (date_nano)
  );

  always_comb begin
    st_d        = st_q;
    pos_d       = pos_q;
    class_d     = class_q;
    id_d        = id_q;
    len_d       = len_q;
    sum_a_d     = sum_a_q;
    sum_b_d     = sum_b_q;
    ck_a_d      = ck_a_q;
    cap_we      = 1'b0;
    pps_d       = pps_q;
    offset_d    = offset_q;
    old_d       = old_q;
    acc_d       = acc_q;
    date_start  = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    ooff_d      = ooff_q;
    corr_d      = corr_q;
    oacc_d      = oacc_q;
    outc_d      = outc_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) st_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) begin
          st_d = ST_IDLE;
          priority if (mode_q == MODE_PPS) begin
            pps_d = now_q;
          end else if (mode_q == MODE_READ) begin
            out_valid_d = 1'b1;
            kind_d      = KIND_READ;
            ooff_d      = offset_q;
            corr_d      = 32'd0;
            oacc_d      = acc_q;
            outc_d      = offset_q + now_q;
          end else if (mode_q == MODE_BYTE) begin
            priority if (pos_q == PW'(0)) begin
              if (byte_q == SYNC_FIRST) pos_d = PW'(1);
            end else if (pos_q == PW'(1)) begin
              pos_d = (byte_q == SYNC_SECOND) ? PW'(2) : PW'(0);
            end else if (pos_q >= PW'(FRAME_BYTES)) begin
              pos_d = PW'(0);
            end else if (pos_q <= PW'(5)) begin
              pos_d   = pos_q + PW'(1);
              sum_a_d = sa_add;
              sum_b_d = sb_add;
              unique case (pos_q[1:0])
                2'd2: class_d = byte_q;
                2'd3: id_d = byte_q;
                2'd0: len_d = {len_q[15:8], byte_q};
                default: len_d = {byte_q, len_q[7:0]};
              endcase
            end else if (32'(k) < 32'(len_q)) begin
              pos_d   = pos_q + PW'(1);
              sum_a_d = sa_add;
              sum_b_d = sb_add;
              cap_we  = 32'(k) < 32'(CAPTURE_LEN);
            end else if (32'(k) == 32'(len_q)) begin
              pos_d  = pos_q + PW'(1);
              ck_a_d = byte_q;
            end else begin
              // second checksum byte closes the frame
              pos_d = PW'(0);
              if (frame_ok && id_q == ID_TIMEUTC) begin
                date_start = 1'b1;
                st_d       = ST_DATE;
              end else if (frame_ok && id_q == ID_CLOCK) begin
                acc_d       = {cap_q[15], cap_q[14], cap_q[13], cap_q[12]};
                out_valid_d = 1'b1;
                kind_d      = KIND_ACC;
                ooff_d      = offset_q;
                corr_d      = 32'd0;
                oacc_d      = {cap_q[15], cap_q[14], cap_q[13], cap_q[12]};
                outc_d      = offset_q + now_q;
              end
            end
          end else begin
            // unused mode: nothing happens
            st_d = ST_IDLE;
          end
        end
      end
      ST_DATE: begin
        if (date_done) begin
          old_d = offset_q;
          if (recent) begin
            offset_d = date_utc - pps_q;
          end else begin
            offset_d = date_utc + 64'($signed(date_nano)) - now_q;
          end
          st_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_d = 1'b1;
        kind_d      = KIND_TIME;
        ooff_d      = offset_q;
        corr_d      = offset_q[31:0] - old_q[31:0];
        oacc_d      = acc_q;
        outc_d      = offset_q + now_q;
        st_d        = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pos_q       <= PW'(FRAME_BYTES);
      class_q     <= 8'd0;
      id_q        <= 8'd0;
      len_q       <= 16'd0;
      sum_a_q     <= 8'd0;
      sum_b_q     <= 8'd0;
      ck_a_q      <= 8'd0;
      window_q    <= PPS_WINDOW_RST;
      pps_q       <= 64'd0;
      offset_q    <= 64'd0;
      old_q       <= 64'd0;
      acc_q       <= ACCURACY_RST;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pos_q       <= pos_d;
      class_q     <= class_d;
      id_q        <= id_d;
      len_q       <= len_d;
      sum_a_q     <= sum_a_d;
      sum_b_q     <= sum_b_d;
      ck_a_q      <= ck_a_d;
      pps_q       <= pps_d;
      offset_q    <= offset_d;
      old_q       <= old_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) window_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      mode_q <= mode_i;
      byte_q <= rx_byte_i;
      now_q  <= now_us_i;
    end
    if (cap_we) cap_q[cap_idx] <= byte_q;
    kind_q <= kind_d;
    ooff_q <= ooff_d;
    corr_q <= corr_d;
    oacc_q <= oacc_d;
    outc_q <= outc_d;
  end

  assign in_stall_o        = (st_q != ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign clock_offset_us_o = ooff_q;
  assign correction_us_o   = $signed(corr_q);
  assign accuracy_ns_o     = oacc_q;
  assign utc_now_us_o      = outc_q;

  `UBXTF_ASSERT_IMP(a_done_in_date, clk_i, rst_ni, date_done, st_q == ST_DATE)
  `UBXTF_ASSERT_IMP(a_date_slot_empty, clk_i, rst_ni, st_q == ST_DATE, !out_valid_q)
  `UBXTF_ASSERT_IMP(a_pos_range, clk_i, rst_ni, 1'b1, pos_q <= PW'(FRAME_BYTES))
  `UBXTF_ASSERT_NXT(a_emit_result, clk_i, rst_ni, st_q == ST_EMIT,
                    out_valid_q && kind_q == KIND_TIME)

endmodule

@@ test/tb_top.sv @@
// self-checking testbench of the ubx time frame receiver: frames, pps, readback, window setting
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ubxtf_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam int unsigned FRAME_LIMIT = 32;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        off;
    logic signed [31:0] corr;
    logic [31:0]        acc;
    logic [63:0]        utc;
  } clk_word_t;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  rx;
    logic [63:0] now;
    bit          typed;
    clk_word_t   want;
  } dir_row_t;

  typedef logic [7:0] pay_t [CAPTURE_LEN];

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         mode_i;
  logic [7:0]         rx_byte_i;
  logic [63:0]        now_us_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         kind_o;
  logic [63:0]        clock_offset_us_o;
  logic signed [31:0] correction_us_o;
  logic [31:0]        accuracy_ns_o;
  logic [63:0]        utc_now_us_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [31:0]        cfg_data_i;

  ubx_time_frame_receiver_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .rx_byte_i, .now_us_i,
    .out_valid_o, .out_stall_i, .kind_o, .clock_offset_us_o, .correction_us_o,
    .accuracy_ns_o, .utc_now_us_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // tracked copy of the block state
  int unsigned  trk_pos;
  logic [7:0]   trk_class, trk_id, trk_sum_a, trk_sum_b, trk_ck_a;
  logic [15:0]  trk_len;
  logic [7:0]   trk_cap [CAPTURE_LEN];
  logic [63:0]  trk_pps, trk_offset;
  logic [31:0]  trk_acc, trk_window;

  clk_word_t    clock_words_q [$];
  int unsigned  errors = 0;
  int unsigned  words_sent = 0;
  int unsigned  hold_left = 0;
  bit           quiet = 0;
  logic [63:0]  now_cur = 64'd0;
  bit           now_frozen = 0;

  function automatic clk_word_t make_word(logic [1:0] kind, logic [31:0] corr, logic [63:0] now);
    clk_word_t w;
    w.kind = kind;
    w.off  = trk_offset;
    w.corr = corr;
    w.acc  = trk_acc;
    w.utc  = trk_offset + now;
    return w;
  endfunction

  function automatic bit apply_frame(logic [63:0] now, output clk_word_t w);
    longint yr, era, yoe, mp, doy, doe, days, nano, mon, dd, nq;
    longint unsigned secs, utc, old;
    logic [31:0] raw;
    w = '0;
    if (trk_class != CLASS_NAV || trk_len != CAPTURE_LEN) return 0;
    if (trk_id == ID_TIMEUTC) begin
      raw  = {trk_cap[11], trk_cap[10], trk_cap[9], trk_cap[8]};
      nano = longint'($signed(raw));
      mon  = longint'(trk_cap[14]);
      dd   = longint'(trk_cap[15]);
      yr   = longint'({trk_cap[13], trk_cap[12]}) - ((mon <= 2) ? 1 : 0) + 400;
      era  = yr / 400;
      yoe  = yr - era * 400;
      mp   = (mon > 2) ? mon - 3 : mon + 9;
      doy  = (153 * mp + 2) / 5 + dd - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = (era - 1) * 146097 + doe - 719468;
      secs = longint'(days) * 86400 + longint'(trk_cap[16]) * 3600
             + longint'(trk_cap[17]) * 60 + longint'(trk_cap[18]);
      utc  = secs * 1000000;
      old  = trk_offset;
      // signed division kept apart from the unsigned sum
      nq   = nano / 1000;
      if (now - trk_pps < {32'd0, trk_window}) begin
        trk_offset = utc - trk_pps;
      end else begin
        trk_offset = utc + nq - now;
      end
      w = make_word(KIND_TIME, 32'(trk_offset - old), now);
      return 1;
    end
    if (trk_id == ID_CLOCK) begin
      trk_acc = {trk_cap[15], trk_cap[14], trk_cap[13], trk_cap[12]};
      w = make_word(KIND_ACC, 32'd0, now);
      return 1;
    end
    return 0;
  endfunction

  function automatic bit parse_byte(logic [7:0] b, logic [63:0] now, output clk_word_t w);
    int unsigned p, k;
    p = trk_pos;
    w = '0;
    if (p == 0 && b != SYNC_FIRST) return 0;
    if (p == 1 && b != SYNC_SECOND) begin
      trk_pos = 0;
      return 0;
    end
    if (p >= FRAME_LIMIT) begin
      trk_pos = 0;
      return 0;
    end
    trk_pos = p + 1;
    if (p < 2) return 0;
    if (p <= 5) begin
      case (p)
        2: begin
          trk_class = b;
          trk_sum_a = 8'd0;
          trk_sum_b = 8'd0;
        end
        3: trk_id = b;
        4: trk_len[7:0] = b;
        default: trk_len[15:8] = b;
      endcase
      trk_sum_a = trk_sum_a + b;
      trk_sum_b = trk_sum_b + trk_sum_a;
      return 0;
    end
    k = p - 6;
    if (k < trk_len) begin
      if (k < CAPTURE_LEN) trk_cap[k] = b;
      trk_sum_a = trk_sum_a + b;
      trk_sum_b = trk_sum_b + trk_sum_a;
      return 0;
    end
    if (k == trk_len) begin
      trk_ck_a = b;
      return 0;
    end
    trk_pos = 0;
    if (trk_ck_a != trk_sum_a || b != trk_sum_b) return 0;
    return apply_frame(now, w);
  endfunction

  function automatic bit clock_predict(logic [1:0] m, logic [7:0] b, logic [63:0] now,
                                       output clk_word_t w);
    w = '0;
    case (m)
      MODE_BYTE: return parse_byte(b, now, w);
      MODE_PPS: begin
        trk_pps = now;
        return 0;
      end
      MODE_READ: begin
        w = make_word(KIND_READ, 32'd0, now);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [63:0] step_now();
    if (!now_frozen) begin
      if ($urandom_range(0, 199) == 0) now_cur = {$urandom, $urandom};
      else now_cur = now_cur + $urandom_range(1, 50);
    end
    return now_cur;
  endfunction

  task automatic put_word(logic [1:0] m, logic [7:0] b, logic [63:0] n,
                          bit typed = 0, clk_word_t want = '0);
    clk_word_t w;
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i     <= m;
    rx_byte_i  <= b;
    now_us_i   <= n;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (clock_predict(m, b, n, w))
      clock_words_q.insert(clock_words_q.size(), typed ? want : w);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(logic [7:0] cls, logic [7:0] id, int unsigned len, pay_t pay,
                            bit bad);
    logic [7:0] sa, sb, hdr [4], v;
    sa = 0;
    sb = 0;
    hdr = '{cls, id, len[7:0], len[15:8]};
    put_word(MODE_BYTE, SYNC_FIRST, step_now());
    put_word(MODE_BYTE, SYNC_SECOND, step_now());
    for (int i = 0; i < 4; i++) begin
      sa = sa + hdr[i];
      sb = sb + sa;
      put_word(MODE_BYTE, hdr[i], step_now());
    end
    for (int i = 0; i < len; i++) begin
      v = (i < CAPTURE_LEN) ? pay[i] : 8'($urandom);
      sa = sa + v;
      sb = sb + sa;
      put_word(MODE_BYTE, v, step_now());
    end
    if (bad) begin
      if ($urandom_range(0, 1)) sa[$urandom_range(0, 7)] ^= 1'b1;
      else sb[$urandom_range(0, 7)] ^= 1'b1;
    end
    put_word(MODE_BYTE, sa, step_now());
    put_word(MODE_BYTE, sb, step_now());
  endtask

  function automatic pay_t timeutc_payload();
    pay_t p;
    logic [15:0] yr;
    for (int i = 0; i < CAPTURE_LEN; i++) p[i] = 8'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      yr = 16'($urandom_range(1970, 2100));
      p[12] = yr[7:0];
      p[13] = yr[15:8];
      p[14] = 8'($urandom_range(1, 12));
      p[15] = 8'($urandom_range(1, 31));
      p[16] = 8'($urandom_range(0, 23));
      p[17] = 8'($urandom_range(0, 59));
      p[18] = 8'($urandom_range(0, 60));
      if ($urandom_range(0, 1)) {p[11], p[10], p[9], p[8]} = 32'($signed($urandom_range(0, 2000000)) - 1000000);
    end
    return p;
  endfunction

  function automatic pay_t any_payload();
    pay_t p;
    for (int i = 0; i < CAPTURE_LEN; i++) p[i] = 8'($urandom);
    return p;
  endfunction

  task automatic write_window(logic [31:0] val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (clock_words_q.size() == 0);
    // a frame that enters the date math always gives a word, so the queue wait covers it
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    trk_window = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver side: random stalls, plus a long hold-off on request
  int unsigned stall_run = 0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 3) == 0);
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin
    clk_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clock_words_q.size() == 0) begin
        $display("%0t unexpected word kind %0d", $realtime, kind_o);
        errors++;
      end else begin
        w = clock_words_q.pop_front();
        if (kind_o !== w.kind) begin
          $display("%0t kind exp %0d got %0d", $realtime, w.kind, kind_o);
          errors++;
        end
        if (clock_offset_us_o !== w.off) begin
          $display("%0t offset exp %h got %h", $realtime, w.off, clock_offset_us_o);
          errors++;
        end
        if (correction_us_o !== w.corr) begin
          $display("%0t correction exp %0d got %0d", $realtime, w.corr, correction_us_o);
          errors++;
        end
        if (accuracy_ns_o !== w.acc) begin
          $display("%0t accuracy exp %h got %h", $realtime, w.acc, accuracy_ns_o);
          errors++;
        end
        if (utc_now_us_o !== w.utc) begin
          $display("%0t utc now exp %h got %h", $realtime, w.utc, utc_now_us_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    dir_row_t dir_tab [12];
    logic [31:0] windows [4];
    int unsigned r, phase_end;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_BYTE;
    rx_byte_i = 8'd0;
    now_us_i = 64'd0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 32'd0;
    trk_pos = FRAME_LIMIT;
    trk_class = 0; trk_id = 0; trk_len = 0;
    trk_sum_a = 0; trk_sum_b = 0; trk_ck_a = 0;
    foreach (trk_cap[i]) trk_cap[i] = 8'd0;
    trk_pps = 0; trk_offset = 0;
    trk_acc = ACCURACY_RST;
    trk_window = PPS_WINDOW_RST;

    // directed rows: overrun drop after reset, readbacks at the extremes, bad sync, an unused-mode word and a pps
    dir_tab[0]  = '{MODE_BYTE, SYNC_FIRST, 64'd5, 0, '0};
    dir_tab[1]  = '{MODE_READ, 8'hFF, 64'd100, 1,
                    '{KIND_READ, 64'd0, 32'sd0, ACCURACY_RST, 64'd100}};
    dir_tab[2]  = '{MODE_IDLE, 8'hFF, 64'd7, 0, '0};
    dir_tab[3]  = '{MODE_READ, 8'h00, '1, 1, '{KIND_READ, 64'd0, 32'sd0, ACCURACY_RST, '1}};
    dir_tab[4]  = '{MODE_BYTE, SYNC_FIRST, 64'd8, 0, '0};
    dir_tab[5]  = '{MODE_BYTE, 8'h00, 64'd9, 0, '0};
    dir_tab[6]  = '{MODE_BYTE, SYNC_SECOND, 64'd10, 0, '0};
    dir_tab[7]  = '{MODE_PPS, 8'h00, '1, 0, '0};
    dir_tab[8]  = '{MODE_READ, 8'h00, 64'd0, 1,
                    '{KIND_READ, 64'd0, 32'sd0, ACCURACY_RST, 64'd0}};
    dir_tab[9]  = '{MODE_BYTE, SYNC_FIRST, 64'd11, 0, '0};
    dir_tab[10] = '{MODE_BYTE, SYNC_FIRST, 64'd12, 0, '0};
    dir_tab[11] = '{MODE_BYTE, 8'hFF, 64'd13, 0, '0};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    quiet = 1;
    foreach (dir_tab[i])
      put_word(dir_tab[i].mode, dir_tab[i].rx, dir_tab[i].now, dir_tab[i].typed, dir_tab[i].want);
    quiet = 0;
    // zero-length frame and a full clock frame, checked by the predictor
    send_frame(CLASS_NAV, ID_CLOCK, 0, any_payload(), 0);
    send_frame(CLASS_NAV, ID_CLOCK, CAPTURE_LEN, any_payload(), 0);

    windows = '{32'd1, 32'hFFFF_FFFF, 32'($urandom_range(100, 5000)), PPS_WINDOW_RST};
    for (int ph = 0; ph < 4; ph++) begin
      write_window(windows[ph]);
      quiet = (ph == 2);
      if (ph == 1) hold_left = 400;
      phase_end = words_sent + 225;
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          if ($urandom_range(0, 1)) put_word(MODE_PPS, 8'($urandom), step_now());
          now_frozen = ($urandom_range(0, 9) < 3);
          send_frame(CLASS_NAV, ID_TIMEUTC, CAPTURE_LEN, timeutc_payload(), 0);
          now_frozen = 0;
        end else if (r < 60) begin
          send_frame(CLASS_NAV, ID_CLOCK, CAPTURE_LEN, any_payload(), 0);
        end else if (r < 66) begin
          send_frame(8'($urandom), 8'($urandom), CAPTURE_LEN, any_payload(), 0);
        end else if (r < 72) begin
          send_frame(CLASS_NAV, ($urandom_range(0, 1) ? ID_TIMEUTC : ID_CLOCK), CAPTURE_LEN,
                     timeutc_payload(), 1);
        end else if (r < 78) begin
          send_frame(CLASS_NAV, ($urandom_range(0, 1) ? ID_TIMEUTC : ID_CLOCK),
                     $urandom_range(0, 30), any_payload(), 0);
        end else if (r < 80) begin
          // longer than the frame buffer: overrun and resync
          send_frame(CLASS_NAV, ID_CLOCK, $urandom_range(25, 120), any_payload(), 0);
        end else if (r < 86) begin
          put_word(MODE_PPS, 8'($urandom), step_now());
        end else if (r < 93) begin
          put_word(MODE_READ, 8'($urandom), step_now());
        end else if (r < 95) begin
          put_word(MODE_IDLE, 8'($urandom), step_now());
        end else begin
          repeat ($urandom_range(1, 6)) put_word(MODE_BYTE, 8'($urandom), step_now());
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (clock_words_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
